// File: rtl/pls_pkg.sv
package pls_pkg;

   // fixed field widths of the request and response beats
   localparam int OP_W      = 3;
   localparam int POS_W     = 4;
   localparam int ELEM_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int ENTRIES_W = 5;

   // default sizing of the store
   localparam int CAPACITY_DEF   = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_APPEND      = 3'd0,
      OP_INSERT      = 3'd1,
      OP_REMOVE_LAST = 3'd2,
      OP_REMOVE_AT   = 3'd3,
      OP_READ        = 3'd4
   } op_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // shift command broadcast to every cell of the row
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_cmd_type;

endpackage

// File: rtl/pls_if.sv
// request channel
interface pls_req_if;
   logic                         valid;
   logic                         ready;
   logic [pls_pkg::OP_W-1:0]     operation;
   logic [pls_pkg::POS_W-1:0]    position;
   logic [pls_pkg::ELEM_W-1:0]   element;

   modport source (output valid, output operation, output position, output element,
                   input ready);
   modport sink   (input valid, input operation, input position, input element,
                   output ready);
endinterface

// response channel
interface pls_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [pls_pkg::STATUS_W-1:0]   status;
   logic [pls_pkg::ELEM_W-1:0]     read_value;
   logic [pls_pkg::ENTRIES_W-1:0]  entries;
   logic                           is_empty;
   logic [pls_pkg::ELEM_W-1:0]     tail_value;

   modport source (output valid, output status, output read_value, output entries,
                   output is_empty, output tail_value, input ready);
   modport sink   (input valid, input status, input read_value, input entries,
                   input is_empty, input tail_value, output ready);
endinterface

// File: rtl/positional_list_store.sv
// channel   | dir | payload                                            | beat when
// req_bus   | in  | operation, position, element                       | valid && ready
// rsp_bus   | out | status, read_value, entries, is_empty, tail_value  | valid && ready
//
// One request at a time: the accept edge updates the row of cells, then the read and
// tail values walk the gather chain; no request is taken until the sweep ends.
// A finished response waits in the output register; the next request is taken
// while it waits, and a stalled response holds the gather sweep at its end.
// Synchronous active-high reset empties the list; slot contents are not cleared.
module positional_list_store #(
   parameter int CAPACITY   = pls_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   pls_req_if.sink   req_bus,
   pls_rsp_if.source rsp_bus
);

   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam int POS_W  = pls_pkg::POS_W;
   localparam int CMP_W  = ((FILL_W > POS_W) ? FILL_W : POS_W) + 1;
   localparam int OUT_W  = pls_pkg::ELEM_W;
   localparam int ENT_W  = pls_pkg::ENTRIES_W;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_SWEEP = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [FILL_W-1:0]       cnt_ff, cnt_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [CMP_W-1:0]        rd_pos_ff, rd_pos_in;
   pls_pkg::status_type     status_ff, status_in;
   logic                    rd_en_ff, rd_en_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   pls_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic [OUT_W-1:0]        rsp_read_ff, rsp_read_in;
   logic [ENT_W-1:0]        rsp_entries_ff, rsp_entries_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic [OUT_W-1:0]        rsp_tail_ff, rsp_tail_in;

   logic                    accept;
   logic                    done;
   logic                    load;
   logic                    list_full;
   logic                    list_empty;
   logic [CMP_W-1:0]        fill_x;
   logic [CMP_W-1:0]        pos_x;
   logic [CMP_W-1:0]        upd_pos;
   logic [FILL_W-1:0]       fill_new;
   pls_pkg::status_type     status_new;
   logic                    rd_new;
   pls_pkg::cell_cmd_type   cmd_new;
   pls_pkg::cell_cmd_type   cell_cmd;
   logic [DATA_WIDTH-1:0]   elem_d;

   logic [DATA_WIDTH-1:0]   slot_val [CAPACITY];
   logic [DATA_WIDTH-1:0]   rd_chain [CAPACITY+1];
   logic [DATA_WIDTH-1:0]   tl_chain [CAPACITY+1];

   // handshake
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   assign fill_x     = CMP_W'(fill_ff);
   assign pos_x      = CMP_W'(req_bus.position);
   assign list_full  = (fill_x == CMP_W'(CAPACITY));
   assign list_empty = (fill_ff == '0);
   assign elem_d     = DATA_WIDTH'(req_bus.element);

   // operation decode against the count before the operation
   always_comb begin
      cmd_new    = '0;
      upd_pos    = pos_x;
      fill_new   = fill_ff;
      status_new = pls_pkg::STATUS_OK;
      rd_new     = 1'b0;
      unique case (req_bus.operation)
         pls_pkg::OP_APPEND: begin
            if (list_full) begin
               status_new = pls_pkg::STATUS_FULL;
            end else begin
               cmd_new.insert = 1'b1;
               upd_pos        = fill_x;
               fill_new       = fill_ff + FILL_W'(1);
            end
         end
         pls_pkg::OP_INSERT: begin
            if (list_full) begin
               status_new = pls_pkg::STATUS_FULL;
            end else begin
               cmd_new.insert = 1'b1;
               upd_pos        = (pos_x < fill_x) ? pos_x : fill_x;
               fill_new       = fill_ff + FILL_W'(1);
            end
         end
         pls_pkg::OP_REMOVE_LAST: begin
            if (list_empty) begin
               status_new = pls_pkg::STATUS_EMPTY;
            end else begin
               fill_new = fill_ff - FILL_W'(1);
            end
         end
         pls_pkg::OP_REMOVE_AT: begin
            if (list_empty) begin
               status_new = pls_pkg::STATUS_EMPTY;
            end else begin
               cmd_new.remove = 1'b1;
               fill_new       = fill_ff - FILL_W'(1);
            end
         end
         pls_pkg::OP_READ: begin
            if (list_empty || pos_x >= fill_x) begin
               status_new = pls_pkg::STATUS_EMPTY;
            end else begin
               rd_new = 1'b1;
            end
         end
         default: begin
            status_new = pls_pkg::STATUS_EMPTY;
         end
      endcase
   end

   assign cell_cmd = accept ? cmd_new : '0;

   // row of cells
   assign rd_chain[CAPACITY] = '0;
   assign tl_chain[CAPACITY] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_val;
      logic [DATA_WIDTH-1:0] right_val;

      if (i == 0) begin : g_first
         assign left_val = '0;
      end else begin : g_mid_l
         assign left_val = slot_val[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_val = '0;
      end else begin : g_mid_r
         assign right_val = slot_val[i+1];
      end

      pls_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .CMP_W      (CMP_W),
         .INDEX      (i)
      ) u_cell (
         .clock        (clock),
         .cmd          (cell_cmd),
         .upd_pos      (upd_pos),
         .fill         (fill_x),
         .rd_pos       (rd_pos_ff),
         .element      (elem_d),
         .left_val     (left_val),
         .right_val    (right_val),
         .rd_chain_in  (rd_chain[i+1]),
         .tl_chain_in  (tl_chain[i+1]),
         .slot_val     (slot_val[i]),
         .rd_chain_out (rd_chain[i]),
         .tl_chain_out (tl_chain[i])
      );
   end

   // sequencer: accept, sweep the gather chain, hand over to the output register
   assign done = (state_ff == ST_SWEEP) && (cnt_ff == FILL_W'(CAPACITY));
   assign load = done && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      fill_in   = fill_ff;
      rd_pos_in = rd_pos_ff;
      status_in = status_ff;
      rd_en_in  = rd_en_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in  = ST_SWEEP;
               cnt_in    = '0;
               fill_in   = fill_new;
               rd_pos_in = pos_x;
               status_in = status_new;
               rd_en_in  = rd_new;
            end
         end
         ST_SWEEP: begin
            if (!done) begin
               cnt_in = cnt_ff + FILL_W'(1);
            end else if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_read_in    = rsp_read_ff;
      rsp_entries_in = rsp_entries_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_tail_in    = rsp_tail_ff;
      if (load) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = status_ff;
         rsp_read_in    = rd_en_ff ? OUT_W'(rd_chain[0]) : '0;
         rsp_entries_in = ENT_W'(fill_ff);
         rsp_empty_in   = (fill_ff == '0);
         rsp_tail_in    = (fill_ff == '0) ? '0 : OUT_W'(tl_chain[0]);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_pos_ff      <= rd_pos_in;
      status_ff      <= status_in;
      rd_en_ff       <= rd_en_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_read_ff    <= rsp_read_in;
      rsp_entries_ff <= rsp_entries_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_tail_ff    <= rsp_tail_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.read_value = rsp_read_ff;
   assign rsp_bus.entries    = rsp_entries_ff;
   assign rsp_bus.is_empty   = rsp_empty_ff;
   assign rsp_bus.tail_value = rsp_tail_ff;

endmodule

// File: rtl/pls_cell.sv
module pls_cell #(
   parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEF,
   parameter int CMP_W      = 6,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  pls_pkg::cell_cmd_type cmd,
   input  logic [CMP_W-1:0]      upd_pos,
   input  logic [CMP_W-1:0]      fill,
   input  logic [CMP_W-1:0]      rd_pos,
   input  logic [DATA_WIDTH-1:0] element,
   input  logic [DATA_WIDTH-1:0] left_val,
   input  logic [DATA_WIDTH-1:0] right_val,
   input  logic [DATA_WIDTH-1:0] rd_chain_in,
   input  logic [DATA_WIDTH-1:0] tl_chain_in,
   output logic [DATA_WIDTH-1:0] slot_val,
   output logic [DATA_WIDTH-1:0] rd_chain_out,
   output logic [DATA_WIDTH-1:0] tl_chain_out
);

   logic [DATA_WIDTH-1:0] slot_ff, slot_in;
   logic [DATA_WIDTH-1:0] rd_gath_ff, rd_gath_in;
   logic [DATA_WIDTH-1:0] tl_gath_ff, tl_gath_in;
   logic [CMP_W-1:0]      my_idx;
   logic [CMP_W-1:0]      my_next;

   assign my_idx  = CMP_W'(INDEX);
   assign my_next = CMP_W'(INDEX + 1);

   // slot update: open a gap toward the tail on insert, close it on remove
   always_comb begin
      slot_in = slot_ff;
      if (cmd.insert) begin
         if (my_idx == upd_pos) begin
            slot_in = element;
         end else if (my_idx > upd_pos && my_idx <= fill) begin
            slot_in = left_val;
         end
      end
      if (cmd.remove) begin
         if (my_idx >= upd_pos && my_next < fill) begin
            slot_in = right_val;
         end
      end
   end

   // gather chains move toward position zero, each cell drops in its slot on a hit
   assign rd_gath_in = (my_idx == rd_pos) ? slot_ff : rd_chain_in;
   assign tl_gath_in = (my_next == fill)  ? slot_ff : tl_chain_in;

   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      rd_gath_ff <= rd_gath_in;
      tl_gath_ff <= tl_gath_in;
   end

   assign slot_val     = slot_ff;
   assign rd_chain_out = rd_gath_ff;
   assign tl_chain_out = tl_gath_ff;

endmodule

// File: rtl/pls_checker.sv
module pls_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [pls_pkg::STATUS_W-1:0]    rsp_status,
   input logic [pls_pkg::ELEM_W-1:0]      rsp_read_value,
   input logic [pls_pkg::ENTRIES_W-1:0]   rsp_entries,
   input logic                            rsp_is_empty,
   input logic [pls_pkg::ELEM_W-1:0]      rsp_tail_value
);

   // a stalled response beat stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // one request at a time: no request beat right after another
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !(req_valid && req_ready))
      else $error("request beats on consecutive cycles");

   // empty flag agrees with the entry count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entries == '0)))
      else $error("empty flag and entry count disagree");

   // an empty list reports no tail
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> (rsp_tail_value == '0))
      else $error("tail value nonzero on empty list");

   // failed operations read nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != pls_pkg::STATUS_OK) |-> (rsp_read_value == '0))
      else $error("read value nonzero on failed operation");

endmodule

bind positional_list_store pls_checker u_pls_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_status     (rsp_bus.status),
   .rsp_read_value (rsp_bus.read_value),
   .rsp_entries    (rsp_bus.entries),
   .rsp_is_empty   (rsp_bus.is_empty),
   .rsp_tail_value (rsp_bus.tail_value)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int CAPACITY    = pls_pkg::CAPACITY_DEF;
   localparam int CYCLE_LIMIT = 250000;
   localparam int RANDOM_OPS  = 750;
   localparam int DRAIN_WAIT  = CAPACITY + 8;
   localparam bit [pls_pkg::OP_W-1:0] OP_CODE_MAX = '1;

   // one response beat, as predicted or as seen on the port
   typedef struct {
      logic [pls_pkg::STATUS_W-1:0]  status;
      logic [pls_pkg::ELEM_W-1:0]    read_value;
      logic [pls_pkg::ENTRIES_W-1:0] entries;
      logic                          is_empty;
      logic [pls_pkg::ELEM_W-1:0]    tail_value;
   } list_reply_type;

   // shadow list plus the queue of replies still owed by the block
   class list_scoreboard;
      bit [pls_pkg::ELEM_W-1:0] words [CAPACITY];
      int                       count;
      list_reply_type           owed_replies [$];
      int                       failures;

      function new();
         count    = 0;
         failures = 0;
         foreach (words[i]) words[i] = '0;
      endfunction

      function int fill_level();
         return count;
      endfunction

      function int owed();
         return owed_replies.size();
      endfunction

      // apply one list operation to the shadow list and form its reply
      function list_reply_type apply_list_op(bit [pls_pkg::OP_W-1:0] op,
                                             bit [pls_pkg::POS_W-1:0] pos,
                                             bit [pls_pkg::ELEM_W-1:0] elem);
         list_reply_type r;
         int             at;
         int             i;
         r.status     = pls_pkg::STATUS_OK;
         r.read_value = '0;
         case (op) inside
            pls_pkg::OP_APPEND, pls_pkg::OP_INSERT: begin
               if (count >= CAPACITY) begin
                  r.status = pls_pkg::STATUS_FULL;
               end else begin
                  at = (op == pls_pkg::OP_INSERT && pos < count) ? int'(pos) : count;
                  for (i = count; i > at; i--) words[i] = words[i-1];
                  words[at] = elem;
                  count++;
               end
            end
            pls_pkg::OP_REMOVE_LAST: begin
               if (count == 0) r.status = pls_pkg::STATUS_EMPTY;
               else count--;
            end
            pls_pkg::OP_REMOVE_AT: begin
               // positions at or past the tail drop the tail
               if (count == 0) begin
                  r.status = pls_pkg::STATUS_EMPTY;
               end else begin
                  for (i = pos; i + 1 < count; i++) words[i] = words[i+1];
                  count--;
               end
            end
            pls_pkg::OP_READ: begin
               if (pos >= count) r.status = pls_pkg::STATUS_EMPTY;
               else r.read_value = words[pos];
            end
            default: r.status = pls_pkg::STATUS_EMPTY;
         endcase
         r.entries    = pls_pkg::ENTRIES_W'(count);
         r.is_empty   = (count == 0);
         r.tail_value = (count == 0) ? '0 : words[count-1];
         return r;
      endfunction

      function void note_request(bit [pls_pkg::OP_W-1:0] op, bit [pls_pkg::POS_W-1:0] pos,
                                 bit [pls_pkg::ELEM_W-1:0] elem);
         owed_replies.push_back(apply_list_op(op, pos, elem));
      endfunction

      function void check_response(list_reply_type got);
         list_reply_type want;
         if (owed_replies.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("[%0t] response beat with no request outstanding", $realtime);
            return;
         end
         want = owed_replies.pop_front();
         if (got.status !== want.status || got.read_value !== want.read_value ||
             got.entries !== want.entries || got.is_empty !== want.is_empty ||
             got.tail_value !== want.tail_value) begin
            failures++;
            if (failures <= 10) begin
               $display("[%0t] response mismatch", $realtime);
               $display("   expected: status %0d read %h entries %0d empty %0d tail %h",
                        want.status, want.read_value, want.entries, want.is_empty,
                        want.tail_value);
               $display("   actual:   status %0d read %h entries %0d empty %0d tail %h",
                        got.status, got.read_value, got.entries, got.is_empty,
                        got.tail_value);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   idle_pct    = 0;
   int   stall_left  = 0;

   list_scoreboard sb = new();

   pls_req_if req_bus ();
   pls_rsp_if rsp_bus ();

   positional_list_store dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // random response backpressure in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready = 1'b0;
         stall_left--;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         rsp_bus.ready = 1'b0;
         stall_left    = $urandom_range(1, 4) - 1;
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   // beat monitor on both channels
   always @(posedge clock) begin
      list_reply_type got;
      if (reset === 1'b0) begin
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            sb.note_request(req_bus.operation, req_bus.position, req_bus.element);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.status     = rsp_bus.status;
            got.read_value = rsp_bus.read_value;
            got.entries    = rsp_bus.entries;
            got.is_empty   = rsp_bus.is_empty;
            got.tail_value = rsp_bus.tail_value;
            sb.check_response(got);
         end
      end
   end

   // drive one request beat, called and returning at a falling edge
   task automatic send_request(input bit [pls_pkg::OP_W-1:0] op,
                               input bit [pls_pkg::POS_W-1:0] pos,
                               input bit [pls_pkg::ELEM_W-1:0] elem);
      int gap;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_bus.valid = 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.operation = op;
      req_bus.position  = pos;
      req_bus.element   = elem;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
   endtask

   // corner cases: empty list, unused codes, clamped positions, full list
   task automatic run_directed();
      int c;
      idle_pct = 20;
      send_request(pls_pkg::OP_REMOVE_LAST, '0, '0);
      send_request(pls_pkg::OP_REMOVE_AT, 4'hf, '0);
      send_request(pls_pkg::OP_READ, '0, '0);
      for (c = pls_pkg::OP_READ + 1; c <= OP_CODE_MAX; c++)
         send_request(pls_pkg::OP_W'(c), 4'hf, '1);
      send_request(pls_pkg::OP_INSERT, 4'hf, 32'h0000_0000);
      send_request(pls_pkg::OP_APPEND, '0, 32'hffff_ffff);
      send_request(pls_pkg::OP_INSERT, '0, 32'h1234_5678);
      send_request(pls_pkg::OP_READ, '0, '0);
      send_request(pls_pkg::OP_READ, 4'hf, '0);
      send_request(pls_pkg::OP_REMOVE_AT, 4'hf, '0);
      send_request(pls_pkg::OP_REMOVE_AT, '0, '0);
      while (sb.fill_level() < CAPACITY)
         send_request(pls_pkg::OP_INSERT, pls_pkg::POS_W'(sb.fill_level() / 2), $urandom);
      send_request(pls_pkg::OP_APPEND, '0, 32'hdead_beef);
      send_request(pls_pkg::OP_INSERT, '0, 32'hcafe_f00d);
      send_request(pls_pkg::OP_READ, 4'hf, '0);
      send_request(pls_pkg::OP_REMOVE_AT, '0, '0);
   endtask

   // random sweeps that alternately grow and shrink the list
   task automatic run_random(input int n);
      int                        k;
      int                        pick;
      int                        level;
      bit                        growing;
      bit [pls_pkg::OP_W-1:0]    op;
      bit [pls_pkg::POS_W-1:0]   pos;
      bit [pls_pkg::ELEM_W-1:0]  elem;
      growing = 1'b1;
      for (k = 0; k < n; k++) begin
         if (k % 50 == 0) begin
            if (k >= n - 100) idle_pct = 0;
            else case ($urandom_range(0, 2))
               0:       idle_pct = 0;
               1:       idle_pct = 15;
               default: idle_pct = 40;
            endcase
         end
         level = sb.fill_level();
         if (level >= CAPACITY) growing = 1'b0;
         else if (level == 0) growing = 1'b1;
         else if ($urandom_range(0, 19) == 0) growing = !growing;

         // operation mix leans toward the current trend
         pick = $urandom_range(0, 99);
         if (pick < 4)
            op = pls_pkg::OP_W'($urandom_range(pls_pkg::OP_READ + 1, OP_CODE_MAX));
         else if (pick < 20)
            op = pls_pkg::OP_READ;
         else if ((pick < 70) == growing)
            op = $urandom_range(0, 1) ? pls_pkg::OP_INSERT : pls_pkg::OP_APPEND;
         else
            op = $urandom_range(0, 1) ? pls_pkg::OP_REMOVE_AT : pls_pkg::OP_REMOVE_LAST;

         if (level > 0 && $urandom_range(0, 3) != 0)
            pos = pls_pkg::POS_W'($urandom_range(0, (level > 15) ? 15 : level));
         else
            pos = pls_pkg::POS_W'($urandom_range(0, 15));

         case ($urandom_range(0, 9))
            0:       elem = '0;
            1:       elem = '1;
            default: elem = $urandom;
         endcase
         send_request(op, pos, elem);
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = '0;
      req_bus.position  = '0;
      req_bus.element   = '0;
      rsp_bus.ready     = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();
      run_random(RANDOM_OPS);
      req_bus.valid = 1'b0;
      idle_pct      = 0;

      // drain outstanding replies, then watch for strays
      while (sb.owed() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (sb.failures == 0 && sb.owed() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// File: sim.f
rtl/pls_pkg.sv
rtl/pls_if.sv
rtl/pls_cell.sv
rtl/positional_list_store.sv
rtl/pls_checker.sv
tb/sv/tb_top.sv
